FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clk edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that expr is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_HOLDS(label, !(expr), msg)

`endif

FILE: src/crlr_pkg.sv
package crlr_pkg;

	localparam int FIELD_W    = 6;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int STEP_W     = 3;

	typedef logic [FIELD_W-1:0] coord_t;
	typedef logic [STEP_W-1:0]  step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SETUP,
		OP_DIV,
		OP_PREP,
		OP_RUN,
		OP_VERT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_WAIT_IN,
		COND_BR_VERT,
		COND_LOOP_DIV,
		COND_EMIT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic vertical;
		logic div_last;
		logic out_free;
		logic last;
	} status_t;

	localparam step_t STEP_LOAD  = 3'd0;
	localparam step_t STEP_SETUP = 3'd1;
	localparam step_t STEP_DIV   = 3'd2;
	localparam step_t STEP_PREP  = 3'd3;
	localparam step_t STEP_RUN   = 3'd4;
	localparam step_t STEP_VERT  = 3'd5;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			STEP_LOAD:  w = '{op: OP_LOAD,  cond: COND_WAIT_IN,  target: STEP_LOAD};
			STEP_SETUP: w = '{op: OP_SETUP, cond: COND_BR_VERT,  target: STEP_VERT};
			STEP_DIV:   w = '{op: OP_DIV,   cond: COND_LOOP_DIV, target: STEP_DIV};
			STEP_PREP:  w = '{op: OP_PREP,  cond: COND_NEXT,     target: STEP_LOAD};
			STEP_RUN:   w = '{op: OP_RUN,   cond: COND_EMIT,     target: STEP_LOAD};
			STEP_VERT:  w = '{op: OP_VERT,  cond: COND_EMIT,     target: STEP_LOAD};
			default:    w = '{op: OP_NOP,   cond: COND_JUMP,     target: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage

FILE: src/crlr_seq.sv
module crlr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  crlr_pkg::status_t status,
	output crlr_pkg::op_t     op
);
	import crlr_pkg::*;

	step_t  step_q;
	step_t  step_next;
	ucode_t uc;

	assign uc = ucode_rom(step_q);
	assign op = uc.op;

	always_comb begin
		step_next = step_q + step_t'(1);
		unique case (uc.cond)
			COND_NEXT:     step_next = step_q + step_t'(1);
			COND_JUMP:     step_next = uc.target;
			COND_WAIT_IN:  if (!status.in_valid) step_next = step_q;
			COND_BR_VERT:  if (status.vertical) step_next = uc.target;
			COND_LOOP_DIV: if (!status.div_last) step_next = step_q;
			COND_EMIT: begin
				if (status.out_free && status.last) step_next = uc.target;
				else step_next = step_q;
			end
			default:       step_next = STEP_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= STEP_LOAD;
		else step_q <= step_next;
	end

endmodule

FILE: src/crlr_dp.sv
module crlr_dp #(
	parameter int SCREEN_WIDTH    = 64,
	parameter int SCREEN_HEIGHT   = 64,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  crlr_pkg::op_t                    op,
	output crlr_pkg::status_t                status,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [crlr_pkg::IN_DATA_W-1:0]   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [crlr_pkg::OUT_DATA_W-1:0]  out_data,
	output logic                             out_empty,
	output logic                             out_last
);
	import crlr_pkg::*;

	localparam int DVD_W = FIELD_W + SLOPE_FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int ROW_W = FIELD_W + 4;
	localparam logic signed [ROW_W-1:0] ROW_MAX   = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [FIELD_W:0]        COL_LIMIT = (FIELD_W + 1)'(SCREEN_WIDTH);

	coord_t ax_q, ay_q, bx_q, by_q;
	coord_t col_q, cnt_q, dvsr_q, rem_q, count_q;
	logic   neg_q;
	logic [DVD_W-1:0] dvd_q, quo_q, y_q;
	logic [CNT_W-1:0] divcnt_q;

	logic   m_valid_q;
	coord_t col_out_q, lo_out_q, hi_out_q;
	logic   empty_out_q, last_out_q;

	logic   swap, dy_neg, fits, emit, out_free, is_vert, last, empty;
	coord_t x0, y0, x1, y1, dy_mag, count_calc, ty, cm1, vmin, vmax, col_sel;
	logic [FIELD_W:0] trial;
	logic signed [ROW_W-1:0] ty_s, cm1_s, lo_sel, hi_sel, lo_c, hi_c;

	assign in_ready = (op == OP_LOAD);
	assign is_vert  = (op == OP_VERT);
	assign out_free = !m_valid_q || out_ready;
	assign emit     = ((op == OP_RUN) || is_vert) && out_free;
	assign last     = is_vert || (cnt_q == coord_t'(1));

	assign swap   = bx_q < ax_q;
	assign x0     = swap ? bx_q : ax_q;
	assign y0     = swap ? by_q : ay_q;
	assign x1     = swap ? ax_q : bx_q;
	assign y1     = swap ? ay_q : by_q;
	assign dy_neg = y1 < y0;
	assign dy_mag = dy_neg ? (y0 - y1) : (y1 - y0);

	assign trial = {rem_q, dvd_q[DVD_W-1]} - {1'b0, dvsr_q};
	assign fits  = !trial[FIELD_W];

	always_comb begin
		count_calc = quo_q[DVD_W-1:SLOPE_FRAC_BITS]
			+ coord_t'(|quo_q[SLOPE_FRAC_BITS-1:0]);
		if (count_calc == '0) count_calc = coord_t'(1);
	end

	assign ty    = y_q[DVD_W-1:SLOPE_FRAC_BITS];
	assign cm1   = count_q - coord_t'(1);
	assign ty_s  = signed'({{(ROW_W - FIELD_W){1'b0}}, ty});
	assign cm1_s = signed'({{(ROW_W - FIELD_W){1'b0}}, cm1});
	assign vmin  = (ay_q < by_q) ? ay_q : by_q;
	assign vmax  = (ay_q < by_q) ? by_q : ay_q;

	always_comb begin
		if (is_vert) begin
			col_sel = ax_q;
			if (vmin == vmax) begin
				lo_sel = ROW_W'(1);
				hi_sel = '0;
			end else begin
				lo_sel = signed'({{(ROW_W - FIELD_W){1'b0}}, vmin});
				hi_sel = signed'({{(ROW_W - FIELD_W){1'b0}}, vmax}) - ROW_W'(1);
			end
		end else begin
			col_sel = col_q;
			lo_sel  = neg_q ? (ty_s - cm1_s) : ty_s;
			hi_sel  = neg_q ? ty_s : (ty_s + cm1_s);
		end
		lo_c  = (lo_sel < 0) ? '0 : lo_sel;
		hi_c  = (hi_sel > ROW_MAX) ? ROW_MAX : hi_sel;
		empty = (lo_c > hi_c) || ({1'b0, col_sel} >= COL_LIMIT);
	end

	assign status.in_valid = in_valid;
	assign status.vertical = (ax_q == bx_q);
	assign status.div_last = (divcnt_q == '0);
	assign status.out_free = out_free;
	assign status.last     = last;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (in_valid) begin
					ax_q <= in_data[FIELD_W-1:0];
					ay_q <= in_data[2*FIELD_W-1:FIELD_W];
					bx_q <= in_data[3*FIELD_W-1:2*FIELD_W];
					by_q <= in_data[4*FIELD_W-1:3*FIELD_W];
				end
			end
			OP_SETUP: begin
				col_q    <= x0;
				cnt_q    <= x1 - x0;
				dvsr_q   <= x1 - x0;
				neg_q    <= dy_neg;
				dvd_q    <= {dy_mag, {SLOPE_FRAC_BITS{1'b0}}};
				rem_q    <= '0;
				quo_q    <= '0;
				divcnt_q <= CNT_W'(DVD_W - 1);
				y_q      <= {y0, {SLOPE_FRAC_BITS{1'b0}}};
			end
			OP_DIV: begin
				dvd_q    <= {dvd_q[DVD_W-2:0], 1'b0};
				rem_q    <= fits ? trial[FIELD_W-1:0] : {rem_q[FIELD_W-2:0], dvd_q[DVD_W-1]};
				quo_q    <= {quo_q[DVD_W-2:0], fits};
				divcnt_q <= divcnt_q - CNT_W'(1);
			end
			OP_PREP: count_q <= count_calc;
			OP_RUN: begin
				if (out_free) begin
					col_q <= col_q + coord_t'(1);
					cnt_q <= cnt_q - coord_t'(1);
					y_q   <= neg_q ? (y_q - quo_q) : (y_q + quo_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			col_out_q   <= col_sel;
			lo_out_q    <= empty ? '0 : lo_c[FIELD_W-1:0];
			hi_out_q    <= empty ? '0 : hi_c[FIELD_W-1:0];
			empty_out_q <= empty;
			last_out_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (emit) m_valid_q <= 1'b1;
		else if (out_ready) m_valid_q <= 1'b0;
	end

	assign out_valid = m_valid_q;
	assign out_data  = {{(OUT_DATA_W - 3*FIELD_W){1'b0}}, hi_out_q, lo_out_q, col_out_q};
	assign out_empty = empty_out_q;
	assign out_last  = last_out_q;

endmodule

FILE: src/column_run_line_rasterizer.sv
// Line rasterizer that emits one vertical run of rows per screen column.
// Slave stream: one request per line, tdata = {end_y, end_x, start_y, start_x}.
// Master stream: one request per run, tdata = {row_high, row_low, column},
// tuser = run_empty, tlast marks the final run of the line.
// Endpoints are ordered by x, the slope is divided out one quotient bit per
// cycle (6 + SLOPE_FRAC_BITS steps), then one run leaves per cycle while the
// receiver is ready. A vertical line or point passes from SETUP straight to
// VERT, which registers its single run; a sloped line passes from SETUP
// through the divide loop and PREP to RUN, which registers its runs in
// column order. No new line is taken until the last run is registered.
// s_axis_tready is high only while the sequencer waits for a new line; the
// final run sits in the output register while the next line is taken.
// A stalled receiver holds the output register and halts the run sequence.
// Reset clears the step counter and the output valid; no result is pending.
module column_run_line_rasterizer #(
	parameter int SCREEN_WIDTH    = 64,
	parameter int SCREEN_HEIGHT   = 64,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
	input  logic [crlr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// column[5:0], row_low[11:6], row_high[17:12], zero[23:18]
	output logic [crlr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// run_empty[0]
	output logic [0:0]                       m_axis_tuser,
	output logic                             m_axis_tlast
);
	import crlr_pkg::*;

	op_t     op;
	status_t status;

	crlr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	crlr_dp #(
		.SCREEN_WIDTH    (SCREEN_WIDTH),
		.SCREEN_HEIGHT   (SCREEN_HEIGHT),
		.SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_empty (m_axis_tuser[0]),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: src/crlr_checker.sv
`include "assert_macros.svh"

module crlr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	`ASSERT_HOLDS(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled run changed")
	`ASSERT_HOLDS(a_busy_after_request, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "line taken while busy")
	`ASSERT_NEVER(a_empty_rows_zero, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[17:6] != 12'd0), "empty run carries rows")
	`ASSERT_NEVER(a_pad_zero, m_axis_tvalid && (m_axis_tdata[23:18] != 6'd0), "tdata padding not zero")

endmodule

bind column_run_line_rasterizer crlr_checker u_crlr_checker (.*);

FILE: bench/column_run_line_rasterizer_tb.sv
module column_run_line_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crlr_pkg::*;

	localparam int SCREEN_W   = 64;
	localparam int SCREEN_H   = 64;
	localparam int FRAC_BITS  = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 40;

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} line_t;

	typedef struct {
		coord_t column;
		coord_t row_low;
		coord_t row_high;
		logic   run_empty;
		logic   last_run;
	} run_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	run_t expected_runs[$];
	int   mismatch_count = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   idle_cycles    = 0;

	column_run_line_rasterizer #(
		.SCREEN_WIDTH   (SCREEN_W),
		.SCREEN_HEIGHT  (SCREEN_H),
		.SLOPE_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void push_run(input int col, input int lo, input int hi,
			input logic last);
		run_t r;
		int   clo;
		int   chi;
		clo = (lo < 0) ? 0 : lo;
		chi = (hi > SCREEN_H - 1) ? SCREEN_H - 1 : hi;
		r.column    = coord_t'(col);
		r.run_empty = (clo > chi) || (col >= SCREEN_W);
		r.row_low   = r.run_empty ? '0 : coord_t'(clo);
		r.row_high  = r.run_empty ? '0 : coord_t'(chi);
		r.last_run  = last;
		expected_runs.push_back(r);
	endfunction

	function automatic void rasterize_line(input line_t ln);
		int     x0, y0, x1, y1, dx, dy, count, ty;
		longint mag, slope, yacc;
		if (ln.sx == ln.ex) begin
			if (ln.sy == ln.ey)
				push_run(ln.sx, 1, 0, 1'b1);
			else if (ln.sy < ln.ey)
				push_run(ln.sx, ln.sy, int'(ln.ey) - 1, 1'b1);
			else
				push_run(ln.sx, ln.ey, int'(ln.sy) - 1, 1'b1);
			return;
		end
		if (ln.ex < ln.sx) begin
			x0 = ln.ex; y0 = ln.ey; x1 = ln.sx; y1 = ln.sy;
		end else begin
			x0 = ln.sx; y0 = ln.sy; x1 = ln.ex; y1 = ln.ey;
		end
		dx    = x1 - x0;
		dy    = y1 - y0;
		mag   = (longint'(dy < 0 ? -dy : dy) << FRAC_BITS) / dx;
		slope = (dy < 0) ? -mag : mag;
		count = int'((mag + (longint'(1) << FRAC_BITS) - 1) >> FRAC_BITS);
		if (count == 0)
			count = 1;
		yacc = longint'(y0) << FRAC_BITS;
		for (int k = 0; k < dx; k++) begin
			ty = (yacc >= 0) ? int'(yacc >>> FRAC_BITS) : -int'((-yacc) >>> FRAC_BITS);
			if (slope > 0)
				push_run(x0 + k, ty, ty + count - 1, k == dx - 1);
			else
				push_run(x0 + k, ty - (count - 1), ty, k == dx - 1);
			yacc += slope;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		run_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_runs.size() == 0) begin
				report_mismatch("run with none pending, column", m_axis_tdata[5:0], 0);
			end else begin
				want = expected_runs.pop_front();
				if (m_axis_tdata[5:0] !== want.column)
					report_mismatch("column", m_axis_tdata[5:0], want.column);
				if (m_axis_tdata[11:6] !== want.row_low)
					report_mismatch("row_low", m_axis_tdata[11:6], want.row_low);
				if (m_axis_tdata[17:12] !== want.row_high)
					report_mismatch("row_high", m_axis_tdata[17:12], want.row_high);
				if (m_axis_tuser[0] !== want.run_empty)
					report_mismatch("run_empty", m_axis_tuser[0], want.run_empty);
				if (m_axis_tlast !== want.last_run)
					report_mismatch("last_run", m_axis_tlast, want.last_run);
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_line(input line_t ln);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ln.ey, ln.ex, ln.sy, ln.sx};
		do @(posedge clk); while (!s_axis_tready);
		rasterize_line(ln);
	endtask

	task automatic send_coords(input int sx, input int sy, input int ex, input int ey);
		line_t ln;
		ln.sx = coord_t'(sx);
		ln.sy = coord_t'(sy);
		ln.ex = coord_t'(ex);
		ln.ey = coord_t'(ey);
		send_line(ln);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (expected_runs.size() != 0);
	endtask

	task automatic test_points_and_vertical();
		send_coords(0, 0, 0, 0);
		send_coords(63, 63, 63, 63);
		send_coords(5, 3, 5, 40);
		send_coords(5, 40, 5, 3);
		send_coords(0, 0, 0, 63);
		send_coords(63, 63, 63, 0);
		send_coords(42, 21, 42, 22);
	endtask

	task automatic test_flat_and_diagonal();
		send_coords(0, 10, 63, 10);
		send_coords(63, 0, 0, 0);
		send_coords(0, 63, 63, 63);
		send_coords(0, 0, 63, 63);
		send_coords(63, 0, 0, 63);
		send_coords(21, 42, 42, 21);
		send_coords(0, 0, 63, 1);
		send_coords(62, 1, 63, 0);
	endtask

	task automatic test_steep_and_clipped();
		send_coords(10, 0, 11, 63);
		send_coords(10, 63, 11, 0);
		send_coords(0, 32, 2, 63);
		send_coords(0, 62, 3, 0);
		send_coords(0, 10, 4, 0);
		send_coords(3, 1, 0, 0);
		send_coords(0, 0, 2, 63);
	endtask

	function automatic line_t random_line();
		line_t ln;
		int    kind;
		kind  = $urandom_range(99);
		ln.sx = coord_t'($urandom_range(63));
		ln.sy = coord_t'($urandom_range(63));
		ln.ex = coord_t'($urandom_range(63));
		ln.ey = coord_t'($urandom_range(63));
		if (kind < 5) begin
			ln.ex = ln.sx;
			ln.ey = ln.sy;
		end else if (kind < 15) begin
			ln.ex = ln.sx;
		end else if (kind < 25) begin
			ln.ey = ln.sy;
		end else if (kind < 40) begin
			ln.ex = coord_t'($urandom_range(ln.sx + 4 > 63 ? 63 : ln.sx + 4,
				ln.sx < 4 ? 0 : ln.sx - 4));
		end
		return ln;
	endfunction

	task automatic test_random(input int n, input int idle_pct, input int stall_pct,
			input int pause_at);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
			end
			send_line(random_line());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_points_and_vertical();
		test_flat_and_diagonal();
		test_steep_and_clipped();
		test_random(37, 0, 0, -1);
		test_random(37, 49, 0, 20);
		test_random(37, 0, 49, -1);
		test_random(37, 25, 25, 30);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/crlr_pkg.sv
src/crlr_seq.sv
src/crlr_dp.sv
src/column_run_line_rasterizer.sv
src/crlr_checker.sv
bench/column_run_line_rasterizer_tb.sv
